>>> sv/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants of the rgb/hsv color converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int unsigned CH_W    = 8;
    localparam int unsigned HUE_W   = 9;
    localparam int unsigned QUO_W   = 9;     // quotient bits, one cell per bit
    localparam int unsigned REM_W   = 22;    // widest dividend 255*15300
    localparam int unsigned DIV_W   = 14;    // widest divisor 15300
    localparam int unsigned NUM_LANES = 3;
    localparam int unsigned TDATA_W = 56;

    localparam logic KIND_TO_HSV = 1'b0;
    localparam logic KIND_TO_RGB = 1'b1;

    localparam logic [DIV_W-1:0] FULL_SCALE  = 14'd255;
    localparam logic [DIV_W-1:0] FRAC_SCALE  = 14'd15300;
    localparam logic [HUE_W-1:0] FULL_CIRCLE = 9'd360;

    typedef enum logic [1:0] {
        HS_RED_POS,
        HS_RED_NEG,
        HS_GREEN,
        HS_BLUE
    } t_hsel;

    // color word and control carried alongside the divider lanes
    typedef struct packed {
        logic              kind;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [HUE_W-1:0]  hue;
        logic [CH_W-1:0]   sat;
        logic [CH_W-1:0]   bri;
        logic              gray;
        t_hsel             hsel;
        logic [2:0]        sector;
    } t_side;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
    } t_lane;

endpackage

>>> sv/rgb_hsv_color_converter.sv
// ----------------------------------------------------------------------------
// rgb_hsv_color_converter
// Converts one color per word between rgb and hsv, direction set by tuser.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output is not stalled and returns one result
// word per input, in order: the prep stages build dividends, a chain of nine
// divider cells settles one quotient bit each, and an output register holds
// the result. The whole pipeline advances whenever the output register is
// empty or being taken, so s_axis_tready follows m_axis_tready directly.
module rgb_hsv_color_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // red, green, blue, hue, saturation, brightness, zero fill
    input  logic [55:0] s_axis_tdata,
    // kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_red, out_green, out_blue, out_hue, out_saturation, out_brightness, zero fill
    output logic [55:0] m_axis_tdata
);
    import rhc_pkg::*;

    logic w_en;
    logic  [QUO_W:0] w_valid;
    t_side [QUO_W:0] w_side;
    t_lane [QUO_W:0][NUM_LANES-1:0] w_lane;

    logic [CH_W-1:0]  w_p, w_q, w_t, n_r, n_g, n_b, n_s, n_v;
    logic [HUE_W-1:0] n_h;
    t_side            w_fs;

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    rhc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_kind  (s_axis_tuser),
        .i_data  (s_axis_tdata),
        .o_valid (w_valid[0]),
        .o_side  (w_side[0]),
        .o_lane  (w_lane[0])
    );

    // cell k settles quotient bit QUO_W-1-k
    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
        rhc_div_cell #(.BIT_POS(QUO_W-1-k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_side  (w_side[k]),
            .i_lane  (w_lane[k]),
            .o_valid (w_valid[k+1]),
            .o_side  (w_side[k+1]),
            .o_lane  (w_lane[k+1])
        );
    end

    assign w_fs = w_side[QUO_W];
    assign w_p  = w_lane[QUO_W][0].quo[CH_W-1:0];
    assign w_q  = w_lane[QUO_W][1].quo[CH_W-1:0];
    assign w_t  = w_lane[QUO_W][2].quo[CH_W-1:0];

    always_comb begin
        n_r = w_fs.red;
        n_g = w_fs.green;
        n_b = w_fs.blue;
        n_h = w_fs.hue;
        n_s = w_fs.sat;
        n_v = w_fs.bri;
        if (w_fs.kind == KIND_TO_HSV) begin
            n_s = w_q;
            unique case (w_fs.hsel)
                HS_RED_NEG: n_h = (w_lane[QUO_W][0].quo == '0) ? '0 :
                                  FULL_CIRCLE - w_lane[QUO_W][0].quo;
                default:    n_h = w_lane[QUO_W][0].quo;
            endcase
            // gray input has no hue and no saturation
            if (w_fs.gray) begin
                n_h = '0;
                n_s = '0;
            end
        end else begin
            case (w_fs.sector)
                3'd0:    begin n_r = w_fs.bri; n_g = w_t; n_b = w_p; end
                3'd1:    begin n_r = w_q; n_g = w_fs.bri; n_b = w_p; end
                3'd2:    begin n_r = w_p; n_g = w_fs.bri; n_b = w_t; end
                3'd3:    begin n_r = w_p; n_g = w_q; n_b = w_fs.bri; end
                3'd4:    begin n_r = w_t; n_g = w_p; n_b = w_fs.bri; end
                default: begin n_r = w_fs.bri; n_g = w_p; n_b = w_q; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (w_en) begin
            m_axis_tvalid <= w_valid[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_axis_tdata <= {7'd0, n_v, n_s, n_h, n_b, n_g, n_r};
        end
    end

endmodule

>>> sv/rhc_prep.sv
// ----------------------------------------------------------------------------
// rhc_prep
// Two register stages that build dividends and divisors for the cell chain.
// ----------------------------------------------------------------------------
module rhc_prep (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic                                   i_kind,
    input  logic [55:0]                            i_data,
    output logic                                   o_valid,
    output rhc_pkg::t_side                         o_side,
    output rhc_pkg::t_lane [rhc_pkg::NUM_LANES-1:0] o_lane
);
    import rhc_pkg::*;

    logic [CH_W-1:0]  w_r, w_g, w_b, w_s, w_v, w_mx, w_mn, w_d;
    logic [HUE_W-1:0] w_h, w_hw, w_f;
    logic [10:0]      w_hbase;
    t_side            n_side;
    logic [2:0]       w_sec;

    logic             r_v1;
    t_side            r_side1;
    logic [16:0]      r_hnum;
    logic [15:0]      r_snum;
    logic [13:0]      r_fs, r_gs;
    logic [CH_W-1:0]  r_ps;
    logic [CH_W-1:0]  r_d;

    assign w_r = i_data[7:0];
    assign w_g = i_data[15:8];
    assign w_b = i_data[23:16];
    assign w_h = i_data[32:24];
    assign w_s = i_data[40:33];
    assign w_v = i_data[48:41];

    always_comb begin
        w_mx = w_r;
        if (w_g > w_mx) w_mx = w_g;
        if (w_b > w_mx) w_mx = w_b;
        w_mn = w_r;
        if (w_g < w_mn) w_mn = w_g;
        if (w_b < w_mn) w_mn = w_b;
        w_d = w_mx - w_mn;
    end

    // hue at or above a full turn wraps once
    always_comb begin
        w_hw = (w_h >= FULL_CIRCLE) ? w_h - FULL_CIRCLE : w_h;
        if (w_hw < 9'd60) begin
            w_sec = 3'd0; w_f = w_hw;
        end else if (w_hw < 9'd120) begin
            w_sec = 3'd1; w_f = w_hw - 9'd60;
        end else if (w_hw < 9'd180) begin
            w_sec = 3'd2; w_f = w_hw - 9'd120;
        end else if (w_hw < 9'd240) begin
            w_sec = 3'd3; w_f = w_hw - 9'd180;
        end else if (w_hw < 9'd300) begin
            w_sec = 3'd4; w_f = w_hw - 9'd240;
        end else begin
            w_sec = 3'd5; w_f = w_hw - 9'd300;
        end
    end

    always_comb begin
        n_side        = '0;
        n_side.kind   = i_kind;
        n_side.red    = w_r;
        n_side.green  = w_g;
        n_side.blue   = w_b;
        n_side.hue    = w_h;
        n_side.sat    = w_s;
        n_side.bri    = w_v;
        n_side.sector = w_sec;
        n_side.gray   = (w_d == '0);
        // ties go to red first, then green
        if (w_mx == w_r) begin
            if (w_g >= w_b) begin
                n_side.hsel = HS_RED_POS;
                w_hbase = 11'(w_g - w_b);
            end else begin
                n_side.hsel = HS_RED_NEG;
                w_hbase = 11'(w_b - w_g);
            end
        end else if (w_mx == w_g) begin
            n_side.hsel = HS_GREEN;
            w_hbase = 11'(w_b) + {2'b0, w_d, 1'b0} - 11'(w_r);
        end else begin
            n_side.hsel = HS_BLUE;
            w_hbase = 11'(w_r) + {1'b0, w_d, 2'b0} - 11'(w_g);
        end
        if (i_kind == KIND_TO_HSV) begin
            n_side.bri = w_mx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= n_side;
            r_hnum  <= 17'(w_hbase) * 17'd60;
            r_snum  <= 16'(w_d) * 16'd255;
            r_d     <= w_d;
            r_fs    <= 14'(w_f) * 14'(w_s);
            r_gs    <= 14'(9'd60 - w_f) * 14'(w_s);
            r_ps    <= 8'd255 - w_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= r_side1;
            if (r_side1.kind == KIND_TO_HSV) begin
                o_lane[0] <= '{rem: REM_W'(r_hnum), dvs: DIV_W'(r_d), quo: '0};
                o_lane[1] <= '{rem: REM_W'(r_snum), dvs: DIV_W'(r_side1.bri), quo: '0};
                o_lane[2] <= '{rem: '0, dvs: DIV_W'(1), quo: '0};
            end else begin
                o_lane[0] <= '{rem: REM_W'(r_side1.bri) * REM_W'(r_ps),
                              dvs: FULL_SCALE, quo: '0};
                o_lane[1] <= '{rem: REM_W'(r_side1.bri) * REM_W'(FRAC_SCALE - r_fs),
                              dvs: FRAC_SCALE, quo: '0};
                o_lane[2] <= '{rem: REM_W'(r_side1.bri) * REM_W'(FRAC_SCALE - r_gs),
                              dvs: FRAC_SCALE, quo: '0};
            end
        end
    end

endmodule

>>> sv/rhc_div_cell.sv
// ----------------------------------------------------------------------------
// rhc_div_cell
// One restoring division step for every lane, settling one quotient bit.
// ----------------------------------------------------------------------------
module rhc_div_cell #(
    parameter int unsigned BIT_POS = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  rhc_pkg::t_side                         i_side,
    input  rhc_pkg::t_lane [rhc_pkg::NUM_LANES-1:0] i_lane,
    output logic                                   o_valid,
    output rhc_pkg::t_side                         o_side,
    output rhc_pkg::t_lane [rhc_pkg::NUM_LANES-1:0] o_lane
);
    import rhc_pkg::*;

    t_lane [NUM_LANES-1:0] n_lane;

    always_comb begin
        logic [REM_W:0] sh;
        for (int i = 0; i < NUM_LANES; i++) begin
            n_lane[i] = i_lane[i];
            sh = (REM_W+1)'(i_lane[i].dvs) << BIT_POS;
            if ({1'b0, i_lane[i].rem} >= sh) begin
                n_lane[i].rem          = REM_W'({1'b0, i_lane[i].rem} - sh);
                n_lane[i].quo[BIT_POS] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            o_lane <= n_lane;
        end
    end

endmodule

>>> sv/rhc_checker.sv
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks of the converter's handshake and pipeline control.
// ----------------------------------------------------------------------------
module rhc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    // pipeline moves exactly when the output register can take a word
    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not track output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word present right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:49] == 7'd0)
        else $error("fill bits of output word not zero");

endmodule

bind rgb_hsv_color_converter rhc_checker u_rhc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
